// File: src/ppi_pkg.sv
// Shared types, register codes and arithmetic helpers of the plane intersection block.
package ppi_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int NDIV_STEPS = 26;
	localparam int PDIV_STEPS = 33;

	// Register codes, one per word of the configuration space.
	localparam logic [2:0] REG_REF_NX = 3'd0;
	localparam logic [2:0] REG_REF_NY = 3'd1;
	localparam logic [2:0] REG_REF_NZ = 3'd2;
	localparam logic [2:0] REG_REF_OX = 3'd3;
	localparam logic [2:0] REG_REF_OY = 3'd4;
	localparam logic [2:0] REG_REF_OZ = 3'd5;
	localparam logic [2:0] REG_THR    = 3'd6;

	localparam logic signed [15:0] RST_REF_NZ = 16'sd16384;
	localparam logic [28:0]        RST_THR    = 29'd1;

	localparam logic signed [25:0] UNIT_ONE = 26'sd16777216;
	localparam logic signed [31:0] PT_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0] PT_MIN   = 32'sh80000000;

	typedef logic signed [15:0] nrm_t;
	typedef logic signed [31:0] crd_t;
	typedef logic signed [25:0] unit_t;

	typedef struct packed {
		logic signed [15:0] other_normal_x;
		logic signed [15:0] other_normal_y;
		logic signed [15:0] other_normal_z;
		logic signed [31:0] other_origin_x;
		logic signed [31:0] other_origin_y;
		logic signed [31:0] other_origin_z;
	} item_in_t;

	typedef struct packed {
		logic               line_found;
		logic signed [15:0] line_dir_x;
		logic signed [15:0] line_dir_y;
		logic signed [15:0] line_dir_z;
		logic signed [31:0] line_point_x;
		logic signed [31:0] line_point_y;
		logic signed [31:0] line_point_z;
		logic               point_saturated;
	} item_out_t;

	// Reference plane as held in the register file.
	typedef struct packed {
		nrm_t [2:0] n;
		crd_t [2:0] o;
		logic [28:0] thr;
	} cfg_t;

	// Square root accumulator: partial remainder and partial root.
	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_acc_t;

	// Lengths of both normals, from the square root pipeline.
	typedef struct packed {
		logic [31:0] len1;
		logic [31:0] len2;
		nrm_t [2:0]  n2;
		crd_t [2:0]  o2;
		logic        zero;
	} root_t;

	// Unit normals of both planes.
	typedef struct packed {
		unit_t [2:0] u1;
		unit_t [2:0] u2;
		crd_t [2:0]  o2;
		logic        zero;
	} unit_pair_t;

	// Line direction and the terms of the point division.
	typedef struct packed {
		logic              found;
		logic [2:0][15:0]  dir;
		logic signed [36:0] num1;
		logic signed [36:0] num2;
		unit_t [2:0]       u1;
		unit_t [2:0]       u2;
		logic [24:0]       det;
	} geom_t;

	// Two radicand bits for square root iteration i of {s, 32'b0}.
	function automatic logic [1:0] sqrt_bits(input logic [31:0] s, input int i);
		logic [63:0] rad;
		rad = {s, 32'd0};
		return rad[2*i +: 2];
	endfunction

	// One digit of the restoring square root.
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] b);
		logic [34:0] r;
		logic [34:0] t;
		sqrt_acc_t o;
		r = {a.rem[32:0], b};
		t = {1'b0, a.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {a.root[30:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// Divide by 2^sh, rounding half away from zero.
	function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
			input int sh);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

	// Clamp to the unit range of a Q1.24 value.
	function automatic unit_t clamp_unit(input logic signed [63:0] v);
		if (v > 64'sd16777216) begin
			return UNIT_ONE;
		end else if (v < -64'sd16777216) begin
			return -UNIT_ONE;
		end
		return unit_t'(v);
	endfunction

endpackage

// File: src/plane_plane_intersection.sv
// Top level: register file, command channel and the intersection pipeline.
//
// Intersects the reference plane in the register file with one other plane
// per item. An item is taken at each rising edge where start is high and busy
// is low; busy is never raised, so a new item may be issued in every cycle.
// Each item yields one result on result, marked by done for one cycle.
// Throughput is one item per cycle: every unit is fully pipelined, and the
// pipeline length is set mainly by the 32-digit square root of the normal
// lengths, the 26-bit unit normal division and the 33-bit division of the
// point by the determinant.
// Results leave in the order the items came; the receiver cannot stall, so
// it must take each result in the cycle done is high.
// Registers are written over the APB port (pready always high) at byte
// address 4*index; the user must do so only while no item is in flight,
// as the block does not check it. Reset clears all pipeline valid bits and
// loads the reference normal (0,0,1), origin zero and parallel threshold 1.
module plane_plane_intersection import ppi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_in_t    item_in,
	output logic        busy,
	output logic        done,
	output item_out_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic        sq_vld, nd_vld, ge_vld;
	root_t       sq_data;
	unit_pair_t  nd_data;
	geom_t       ge_data;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n   <= {RST_REF_NZ, 16'sd0, 16'sd0};
			cfg_q.o   <= '0;
			cfg_q.thr <= RST_THR;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_REF_NX: cfg_q.n[0] <= pwdata[15:0];
				REG_REF_NY: cfg_q.n[1] <= pwdata[15:0];
				REG_REF_NZ: cfg_q.n[2] <= pwdata[15:0];
				REG_REF_OX: cfg_q.o[0] <= pwdata;
				REG_REF_OY: cfg_q.o[1] <= pwdata;
				REG_REF_OZ: cfg_q.o[2] <= pwdata;
				REG_THR:    cfg_q.thr  <= pwdata[28:0];
				default: ;
			endcase
		end
	end

	// Register file reads.
	always_comb begin
		case (paddr[4:2])
			REG_REF_NX: prdata = {16'd0, cfg_q.n[0]};
			REG_REF_NY: prdata = {16'd0, cfg_q.n[1]};
			REG_REF_NZ: prdata = {16'd0, cfg_q.n[2]};
			REG_REF_OX: prdata = cfg_q.o[0];
			REG_REF_OY: prdata = cfg_q.o[1];
			REG_REF_OZ: prdata = cfg_q.o[2];
			REG_THR:    prdata = {3'd0, cfg_q.thr};
			default:    prdata = '0;
		endcase
	end

	ppi_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.in_data  (item_in),
		.cfg      (cfg_q),
		.out_vld  (sq_vld),
		.out_data (sq_data)
	);

	ppi_ndiv u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.in_data  (sq_data),
		.cfg      (cfg_q),
		.out_vld  (nd_vld),
		.out_data (nd_data)
	);

	ppi_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (nd_vld),
		.in_data  (nd_data),
		.cfg      (cfg_q),
		.out_vld  (ge_vld),
		.out_data (ge_data)
	);

	ppi_pdiv u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ge_vld),
		.in_data  (ge_data),
		.out_vld  (done),
		.out_data (result)
	);

	// A result without a line carries no direction, point or flag.
	a_no_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.line_found |-> result.line_dir_x == 16'sd0 &&
		result.line_dir_y == 16'sd0 && result.line_dir_z == 16'sd0 &&
		result.line_point_x == 32'sd0 && result.line_point_y == 32'sd0 &&
		result.line_point_z == 32'sd0 && !result.point_saturated)
		else $error("no-line result has nonzero fields");

	// A saturation flag means some coordinate sits at a range limit.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.point_saturated |->
		result.line_point_x == PT_MAX || result.line_point_x == PT_MIN ||
		result.line_point_y == PT_MAX || result.line_point_y == PT_MIN ||
		result.line_point_z == PT_MAX || result.line_point_z == PT_MIN)
		else $error("saturation flag without a clipped coordinate");

	// A threshold write lands in the register file.
	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && paddr[4:2] == REG_THR |=> cfg_q.thr == $past(pwdata[28:0]))
		else $error("threshold write lost");

endmodule

// File: src/ppi_isqrt.sv
// Sums of squares and pipelined square roots of both plane normals.
module ppi_isqrt import ppi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_vld,
	input  item_in_t in_data,
	input  cfg_t     cfg,
	output logic     out_vld,
	output root_t    out_data
);

	typedef struct packed {
		sqrt_acc_t   a1;
		sqrt_acc_t   a2;
		logic [31:0] s1;
		logic [31:0] s2;
		nrm_t [2:0]  n2;
		crd_t [2:0]  o2;
		logic        zero;
	} sq_stage_t;

	sq_stage_t            pipe_s [0:SQRT_STEPS];
	sq_stage_t            step_nx [SQRT_STEPS];
	logic [SQRT_STEPS:0]  vld_s;
	sq_stage_t            entry;
	logic signed [31:0]   a;
	logic signed [31:0]   b;

	// Entry: squared lengths of the reference and the incoming normal.
	always_comb begin
		entry      = '0;
		entry.n2   = {in_data.other_normal_z, in_data.other_normal_y,
			in_data.other_normal_x};
		entry.o2   = {in_data.other_origin_z, in_data.other_origin_y,
			in_data.other_origin_x};
		a = '0;
		b = '0;
		for (int i = 0; i < 3; i++) begin
			a = 32'($signed(cfg.n[i]));
			b = 32'($signed(entry.n2[i]));
			entry.s1 = entry.s1 + 32'(a * a);
			entry.s2 = entry.s2 + 32'(b * b);
		end
		entry.zero = (entry.s1 == 32'd0) || (entry.s2 == 32'd0);
	end

	// Valid bits travel with the square root digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQRT_STEPS-1:0], in_vld};
		end
	end

	// Next root digit of both normals for every stage.
	always_comb begin
		for (int g = 0; g < SQRT_STEPS; g++) begin
			step_nx[g]    = pipe_s[g];
			step_nx[g].a1 = sqrt_step(pipe_s[g].a1,
				sqrt_bits(pipe_s[g].s1, SQRT_STEPS - 1 - g));
			step_nx[g].a2 = sqrt_step(pipe_s[g].a2,
				sqrt_bits(pipe_s[g].s2, SQRT_STEPS - 1 - g));
		end
	end

	// One root digit per stage for both normals.
	always_ff @(posedge clk) begin
		pipe_s[0] <= entry;
		for (int g = 0; g < SQRT_STEPS; g++) begin
			pipe_s[g+1] <= step_nx[g];
		end
	end

	assign out_vld       = vld_s[SQRT_STEPS];
	assign out_data.len1 = pipe_s[SQRT_STEPS].a1.root;
	assign out_data.len2 = pipe_s[SQRT_STEPS].a2.root;
	assign out_data.n2   = pipe_s[SQRT_STEPS].n2;
	assign out_data.o2   = pipe_s[SQRT_STEPS].o2;
	assign out_data.zero = pipe_s[SQRT_STEPS].zero;

endmodule

// File: src/ppi_ndiv.sv
// Pipelined divisions that scale both normals to unit length.
module ppi_ndiv import ppi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_vld,
	input  root_t      in_data,
	input  cfg_t       cfg,
	output logic       out_vld,
	output unit_pair_t out_data
);

	typedef struct packed {
		logic        neg;
		logic [31:0] rem;
		logic [25:0] q;
		logic [25:0] lo;
	} nd_lane_t;

	typedef struct packed {
		nd_lane_t [5:0] lane;
		logic [31:0]    len1;
		logic [31:0]    len2;
		crd_t [2:0]     o2;
		logic           zero;
	} nd_stage_t;

	nd_stage_t             pipe_s [0:NDIV_STEPS];
	nd_stage_t             step_nx [NDIV_STEPS];
	logic [NDIV_STEPS+1:0] vld_s;
	unit_pair_t            unit_s;
	nd_stage_t             entry;
	nrm_t                  nv;
	logic [31:0]           len;
	logic [15:0]           mag;
	logic [56:0]           m;
	nd_stage_t             last;
	unit_pair_t            fin;
	logic [25:0]           qc;

	// One quotient bit of a restoring division by the normal length.
	function automatic nd_lane_t nd_step(input nd_lane_t l, input logic [31:0] d);
		logic [32:0] r;
		nd_lane_t o;
		r     = {l.rem, l.lo[25]};
		o     = l;
		o.lo  = {l.lo[24:0], 1'b0};
		if (r >= {1'b0, d}) begin
			o.rem = 32'(r - {1'b0, d});
			o.q   = {l.q[24:0], 1'b1};
		end else begin
			o.rem = r[31:0];
			o.q   = {l.q[24:0], 1'b0};
		end
		return o;
	endfunction

	// Setup: rounded dividend |n| * 2^40 + len/2; its top part seeds the remainder.
	always_comb begin
		entry      = '0;
		entry.len1 = in_data.len1;
		entry.len2 = in_data.len2;
		entry.o2   = in_data.o2;
		entry.zero = in_data.zero;
		nv  = '0;
		len = '0;
		mag = '0;
		m   = '0;
		for (int i = 0; i < 6; i++) begin
			nv  = (i < 3) ? cfg.n[i % 3] : in_data.n2[i % 3];
			len = (i < 3) ? in_data.len1 : in_data.len2;
			mag = nv[15] ? 16'(-nv) : 16'(nv);
			m   = {1'b0, mag, 40'd0} + 57'(len[31:1]);
			entry.lane[i].neg = nv[15];
			entry.lane[i].rem = {1'b0, m[56:26]};
			entry.lane[i].q   = '0;
			entry.lane[i].lo  = m[25:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NDIV_STEPS:0], in_vld};
		end
	end

	// Final stage: apply the sign and clamp to unit range.
	always_comb begin
		last = pipe_s[NDIV_STEPS];
		fin      = '0;
		fin.o2   = last.o2;
		fin.zero = last.zero;
		qc = '0;
		for (int i = 0; i < 6; i++) begin
			qc = (last.lane[i].q > 26'd16777216) ? 26'd16777216 : last.lane[i].q;
			if (i < 3) begin
				fin.u1[i % 3] = last.lane[i].neg ? -$signed(qc) : $signed(qc);
			end else begin
				fin.u2[i % 3] = last.lane[i].neg ? -$signed(qc) : $signed(qc);
			end
		end
	end

	// Next quotient bit of all six lanes for every stage.
	always_comb begin
		for (int g = 0; g < NDIV_STEPS; g++) begin
			step_nx[g] = pipe_s[g];
			for (int i = 0; i < 6; i++) begin
				step_nx[g].lane[i] = nd_step(pipe_s[g].lane[i],
					(i < 3) ? pipe_s[g].len1 : pipe_s[g].len2);
			end
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= entry;
		for (int g = 0; g < NDIV_STEPS; g++) begin
			pipe_s[g+1] <= step_nx[g];
		end
		unit_s <= fin;
	end

	assign out_vld  = vld_s[NDIV_STEPS+1];
	assign out_data = unit_s;

endmodule

// File: src/ppi_geom.sv
// Cross product, parallel test, offsets, determinant and point numerators.
module ppi_geom import ppi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_vld,
	input  unit_pair_t in_data,
	input  cfg_t       cfg,
	output logic       out_vld,
	output geom_t      out_data
);

	logic [5:1]         vld_s;
	unit_pair_t         up_s1, up_s2, up_s3, up_s4;
	logic signed [51:0] pc_s1 [6];
	logic signed [51:0] pk_s1 [3];
	logic signed [57:0] po1_s1 [3];
	logic signed [57:0] po2_s1 [3];
	logic signed [51:0] cr_s2 [3];
	logic signed [51:0] dot_s2;
	logic signed [59:0] dd1_s2, dd2_s2;
	logic signed [26:0] c24_s3 [3];
	logic [15:0]        dir_s3 [3];
	unit_t              k_s3;
	logic signed [34:0] d1_s3, d2_s3;
	logic signed [53:0] csq_s4 [3];
	logic signed [51:0] kk_s4;
	logic signed [60:0] d2k_s4, d1k_s4;
	logic signed [34:0] d1_s4, d2_s4;
	logic [15:0]        dir_s4 [3];
	geom_t              geo_s5;
	logic [55:0]        sq;
	logic signed [63:0] dt;
	logic               par;
	geom_t              nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[4:1], in_vld};
		end
	end

	// Stage 5 logic: parallel test, determinant and numerators.
	always_comb begin
		sq = 56'(csq_s4[0]) + 56'(csq_s4[1]) + 56'(csq_s4[2]);
		par = (sq >> 20) < 56'(cfg.thr);
		dt = rshr((64'sd1 <<< 48) - 64'(kk_s4), 24);
		nxt       = '0;
		nxt.found = !up_s4.zero && !par && !dt[63] && (dt != 64'sd0);
		nxt.det   = dt[24:0];
		nxt.num1  = 37'(rshr((64'(d1_s4) <<< 24) - 64'(d2k_s4), 24));
		nxt.num2  = 37'(rshr((64'(d2_s4) <<< 24) - 64'(d1k_s4), 24));
		nxt.u1    = up_s4.u1;
		nxt.u2    = up_s4.u2;
		for (int i = 0; i < 3; i++) begin
			nxt.dir[i] = dir_s4[i];
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: all products of the unit normals and origins.
		pc_s1[0] <= $signed(in_data.u1[1]) * $signed(in_data.u2[2]);
		pc_s1[1] <= $signed(in_data.u1[2]) * $signed(in_data.u2[1]);
		pc_s1[2] <= $signed(in_data.u1[2]) * $signed(in_data.u2[0]);
		pc_s1[3] <= $signed(in_data.u1[0]) * $signed(in_data.u2[2]);
		pc_s1[4] <= $signed(in_data.u1[0]) * $signed(in_data.u2[1]);
		pc_s1[5] <= $signed(in_data.u1[1]) * $signed(in_data.u2[0]);
		for (int i = 0; i < 3; i++) begin
			pk_s1[i]  <= $signed(in_data.u1[i]) * $signed(in_data.u2[i]);
			po1_s1[i] <= $signed(in_data.u1[i]) * $signed(cfg.o[i]);
			po2_s1[i] <= $signed(in_data.u2[i]) * $signed(in_data.o2[i]);
		end
		up_s1 <= in_data;

		// Stage 2: cross product and dot product sums.
		for (int i = 0; i < 3; i++) begin
			cr_s2[i] <= pc_s1[2*i] - pc_s1[2*i+1];
		end
		dot_s2 <= pk_s1[0] + pk_s1[1] + pk_s1[2];
		dd1_s2 <= 60'(po1_s1[0]) + 60'(po1_s1[1]) + 60'(po1_s1[2]);
		dd2_s2 <= 60'(po2_s1[0]) + 60'(po2_s1[1]) + 60'(po2_s1[2]);
		up_s2  <= up_s1;

		// Stage 3: rounding to working precision, with the dot product clamped to unit range.
		for (int i = 0; i < 3; i++) begin
			c24_s3[i] <= 27'(rshr(64'(cr_s2[i]), 24));
			dir_s3[i] <= 16'(rshr(64'(cr_s2[i]), 34));
		end
		k_s3  <= clamp_unit(rshr(64'(dot_s2), 24));
		d1_s3 <= 35'(rshr(64'(dd1_s2), 24));
		d2_s3 <= 35'(rshr(64'(dd2_s2), 24));
		up_s3 <= up_s2;

		// Stage 4: squares and offset products.
		for (int i = 0; i < 3; i++) begin
			csq_s4[i] <= c24_s3[i] * c24_s3[i];
			dir_s4[i] <= dir_s3[i];
		end
		kk_s4  <= k_s3 * k_s3;
		d2k_s4 <= d2_s3 * k_s3;
		d1k_s4 <= d1_s3 * k_s3;
		d1_s4  <= d1_s3;
		d2_s4  <= d2_s3;
		up_s4  <= up_s3;

		// Stage 5.
		geo_s5 <= nxt;
	end

	assign out_vld  = vld_s[5];
	assign out_data = geo_s5;

endmodule

// File: src/ppi_pdiv.sv
// Point products, pipelined rounded division by the determinant and saturation.
module ppi_pdiv import ppi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	input  geom_t     in_data,
	output logic      out_vld,
	output item_out_t out_data
);

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [24:0] rem;
		logic [32:0] q;
		logic [32:0] lo;
	} pd_lane_t;

	typedef struct packed {
		pd_lane_t [2:0]   lane;
		logic [24:0]      det;
		logic             found;
		logic [2:0][15:0] dir;
	} pd_stage_t;

	logic signed [62:0]    pa_s1 [3];
	logic signed [62:0]    pb_s1 [3];
	geom_t                 geo_s1;
	pd_stage_t             pipe_s [0:PDIV_STEPS];
	pd_stage_t             step_nx [PDIV_STEPS];
	logic [PDIV_STEPS+2:0] vld_s;
	item_out_t             res_s;
	pd_stage_t             entry;
	logic signed [63:0]    t;
	logic [63:0]           m;
	logic [63:0]           lim;
	pd_stage_t             last;
	item_out_t             fin;
	logic signed [31:0]    pt [3];
	logic [2:0]            sat;

	// One quotient bit of a restoring division by the determinant.
	function automatic pd_lane_t pd_step(input pd_lane_t l, input logic [24:0] d);
		logic [25:0] r;
		pd_lane_t o;
		r    = {l.rem, l.lo[32]};
		o    = l;
		o.lo = {l.lo[31:0], 1'b0};
		if (r >= {1'b0, d}) begin
			o.rem = 25'(r - {1'b0, d});
			o.q   = {l.q[31:0], 1'b1};
		end else begin
			o.rem = r[24:0];
			o.q   = {l.q[31:0], 1'b0};
		end
		return o;
	endfunction

	// Setup: magnitude plus half the divisor; a quotient past 33 bits saturates.
	always_comb begin
		entry       = '0;
		entry.det   = geo_s1.det;
		entry.found = geo_s1.found;
		entry.dir   = geo_s1.dir;
		lim = {6'd0, geo_s1.det, 33'd0};
		t   = '0;
		m   = '0;
		for (int i = 0; i < 3; i++) begin
			t = 64'(pa_s1[i]) + 64'(pb_s1[i]);
			m = t[63] ? 64'(-t) : 64'(t);
			m = m + 64'(geo_s1.det[24:1]);
			entry.lane[i].neg = t[63];
			entry.lane[i].ovf = (m >= lim);
			entry.lane[i].rem = (m >= lim) ? 25'd0 : m[57:33];
			entry.lane[i].q   = '0;
			entry.lane[i].lo  = m[32:0];
		end
	end

	// Final: sign, clip to 32 bits, and zero everything when no line exists.
	always_comb begin
		last = pipe_s[PDIV_STEPS];
		for (int i = 0; i < 3; i++) begin
			pt[i]  = '0;
			sat[i] = 1'b0;
			if (last.lane[i].ovf) begin
				sat[i] = 1'b1;
				pt[i]  = last.lane[i].neg ? PT_MIN : PT_MAX;
			end else if (last.lane[i].neg) begin
				if (last.lane[i].q > 33'h080000000) begin
					sat[i] = 1'b1;
					pt[i]  = PT_MIN;
				end else begin
					pt[i] = 32'(-$signed({1'b0, last.lane[i].q}));
				end
			end else begin
				if (last.lane[i].q > 33'h07fffffff) begin
					sat[i] = 1'b1;
					pt[i]  = PT_MAX;
				end else begin
					pt[i] = $signed(last.lane[i].q[31:0]);
				end
			end
		end
		fin = '0;
		if (last.found) begin
			fin.line_found      = 1'b1;
			fin.line_dir_x      = $signed(last.dir[0]);
			fin.line_dir_y      = $signed(last.dir[1]);
			fin.line_dir_z      = $signed(last.dir[2]);
			fin.line_point_x    = pt[0];
			fin.line_point_y    = pt[1];
			fin.line_point_z    = pt[2];
			fin.point_saturated = |sat;
		end
	end

	// Next quotient bit of the three lanes for every stage.
	always_comb begin
		for (int g = 0; g < PDIV_STEPS; g++) begin
			step_nx[g] = pipe_s[g];
			for (int i = 0; i < 3; i++) begin
				step_nx[g].lane[i] = pd_step(pipe_s[g].lane[i], pipe_s[g].det);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PDIV_STEPS+1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		// Products of the numerators with the unit normals.
		for (int i = 0; i < 3; i++) begin
			pa_s1[i] <= in_data.num1 * $signed(in_data.u1[i]);
			pb_s1[i] <= in_data.num2 * $signed(in_data.u2[i]);
		end
		geo_s1    <= in_data;
		pipe_s[0] <= entry;
		for (int g = 0; g < PDIV_STEPS; g++) begin
			pipe_s[g+1] <= step_nx[g];
		end
		res_s <= fin;
	end

	assign out_vld  = vld_s[PDIV_STEPS+2];
	assign out_data = res_s;

endmodule
